@@ src/plf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plf_pkg
// shared item types, event and function codes for the preamble frame loader
// ----------------------------------------------------------------------------
package plf_pkg;

	// function codes of an input item
	localparam logic [1:0] FUNC_RX      = 2'd0;
	localparam logic [1:0] FUNC_RELEASE = 2'd1;
	localparam logic [1:0] FUNC_READ    = 2'd2;

	// event codes of a result item
	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_JUNK    = 3'd1;
	localparam logic [2:0] EV_DONE    = 3'd2;
	localparam logic [2:0] EV_REFUSED = 3'd3;
	localparam logic [2:0] EV_READ    = 3'd4;

	// preamble definition
	localparam logic [7:0] PREAMBLE_BYTE = 8'hFF;
	localparam logic [2:0] PREAMBLE_LEN  = 3'd4;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_byte;
		logic [7:0] read_index;
	} plf_in_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [1:0] junk_count;
		logic [7:0] junk_byte;
		logic       ready_bank;
		logic [7:0] read_data;
	} plf_out_t;

	// result info of an item waiting for the memory read data
	typedef struct packed {
		logic [2:0] event_res;
		logic [1:0] junk_count;
		logic [7:0] junk_byte;
		logic       ready_bank;
		logic       rd_ok;
	} plf_s1_t;

endpackage

@@ src/plf_bank_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plf_bank_mem
// two ping-pong byte banks in one memory, one write and one registered read
// ----------------------------------------------------------------------------
module plf_bank_mem #(
	parameter int BANK_BYTES = 256
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [$clog2(BANK_BYTES):0]     waddr,
	input  logic [7:0]                      wdata,
	input  logic                            re,
	input  logic [$clog2(BANK_BYTES):0]     raddr,
	output logic [7:0]                      rdata
);
	// bank select is the top address bit, so each bank spans a power of two
	localparam int DEPTH = 2 ** ($clog2(BANK_BYTES) + 1);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/plf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plf_ctrl
// preamble hunt, length count, bank fill and swap; issues memory accesses
// ----------------------------------------------------------------------------
module plf_ctrl #(
	parameter int BANK_BYTES = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_fire,
	input  plf_pkg::plf_in_t                in_item,
	output logic                            mem_we,
	output logic [$clog2(BANK_BYTES):0]     mem_waddr,
	output logic [7:0]                      mem_wdata,
	output logic                            mem_re,
	output logic [$clog2(BANK_BYTES):0]     mem_raddr,
	output plf_pkg::plf_s1_t                info_s1
);
	import plf_pkg::*;

	localparam int IW = $clog2(BANK_BYTES);
	localparam int WW = $clog2(BANK_BYTES + 1);

	logic [2:0]    seen_q, seen_d;
	logic [7:0]    remain_q, remain_d;
	logic [WW-1:0] widx_q, widx_d;
	logic          fill_q, fill_d;
	logic          wait_q, wait_d;
	plf_s1_t       info_d;

	always_comb begin
		seen_d    = seen_q;
		remain_d  = remain_q;
		widx_d    = widx_q;
		fill_d    = fill_q;
		wait_d    = wait_q;
		info_d    = '0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = {fill_q, widx_q[IW-1:0]};
		mem_wdata = in_item.data_byte;
		mem_raddr = {~fill_q, in_item.read_index[IW-1:0]};
		case (in_item.func)
			FUNC_RX: begin
				if (wait_q) begin
					info_d.event_res = EV_REFUSED;
				end else if (remain_q == 8'd0) begin
					if (seen_q >= PREAMBLE_LEN) begin
						// length byte; zero keeps hunting
						remain_d = in_item.data_byte;
						seen_d   = 3'd0;
					end else if (in_item.data_byte == PREAMBLE_BYTE) begin
						seen_d = seen_q + 3'd1;
					end else begin
						info_d.event_res  = EV_JUNK;
						info_d.junk_count = (seen_q > 3'd3) ? 2'd3 : seen_q[1:0];
						info_d.junk_byte  = in_item.data_byte;
						seen_d            = 3'd0;
					end
				end else begin
					// bytes past the bank end are counted only
					if (widx_q < WW'(BANK_BYTES)) begin
						mem_we = in_fire;
						widx_d = widx_q + WW'(1);
					end
					remain_d = remain_q - 8'd1;
					if (remain_q == 8'd1) begin
						info_d.event_res = EV_DONE;
						wait_d           = 1'b1;
						fill_d           = ~fill_q;
						widx_d           = '0;
					end
				end
			end
			FUNC_RELEASE: begin
				wait_d = 1'b0;
			end
			FUNC_READ: begin
				info_d.event_res = EV_READ;
				info_d.rd_ok     = ({1'b0, in_item.read_index} < 9'(BANK_BYTES));
				mem_re           = in_fire;
			end
			default: begin
			end
		endcase
		info_d.ready_bank = ~fill_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= '0;
			remain_q <= '0;
			widx_q   <= '0;
			fill_q   <= 1'b0;
			wait_q   <= 1'b0;
		end else if (in_fire) begin
			seen_q   <= seen_d;
			remain_q <= remain_d;
			widx_q   <= widx_d;
			fill_q   <= fill_d;
			wait_q   <= wait_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			info_s1 <= info_d;
		end
	end

endmodule

@@ src/plf_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plf_out_stage
// merges read data with result info and holds the output item
// ----------------------------------------------------------------------------
module plf_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  plf_pkg::plf_s1_t   info_s1,
	input  logic [7:0]         mem_rdata,
	output logic               s1_free,
	output logic               out_valid,
	input  logic               out_ready,
	output plf_pkg::plf_out_t  out_item
);
	import plf_pkg::*;

	logic     valid_s1;
	logic     out_valid_q;
	logic     adv;
	plf_out_t item_d;
	plf_out_t out_q;

	assign adv     = !out_valid_q || out_ready;
	assign s1_free = !valid_s1 || adv;

	always_comb begin
		item_d.event_res  = info_s1.event_res;
		item_d.junk_count = info_s1.junk_count;
		item_d.junk_byte  = info_s1.junk_byte;
		item_d.ready_bank = info_s1.ready_bank;
		item_d.read_data  = (info_s1.event_res == EV_READ && info_s1.rd_ok) ? mem_rdata : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out_q <= item_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

@@ src/preamble_frame_pingpong_loader_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preamble_frame_pingpong_loader_core
// preamble/length deframer loading two ping-pong byte banks
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid/in_ready/in_item): received bytes, bank release and
//   bank read items. out channel (out_valid/out_ready/out_item): exactly one
//   result item per input item, in input order.
//   path: the accept edge captures the result info and the bank read in the
//   read stage; the output register is loaded from it when the read stage
//   advances, and out_valid rises as it is loaded.
//   throughput: one item per cycle outside a stall; control state updates at
//   the accept edge, so the next byte needs nothing from the memory pipeline.
//   stall: a result waiting on out_ready sits in the output register while
//   one more item moves into the read stage; in_ready drops only when both
//   are full.
//   reset: arst_n clears the hunt, length, fill index, bank select and the
//   frame-waiting flag at once; bank contents are not cleared, so no clearing
//   pass is needed and in_ready is high as soon as reset is released.
// ----------------------------------------------------------------------------
module preamble_frame_pingpong_loader_core #(
	parameter int BANK_BYTES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  plf_pkg::plf_in_t   in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output plf_pkg::plf_out_t  out_item
);
	import plf_pkg::*;

	localparam int AW = $clog2(BANK_BYTES) + 1;

	logic          in_fire;
	logic          s1_free;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;
	plf_s1_t       info_s1;

	// take an item whenever the read stage is empty or moving on
	assign in_ready = s1_free;
	assign in_fire  = in_valid && s1_free;

	// hunt/fill state; writes go to the fill bank, reads to the other bank,
	// so a write and a read in one cycle never touch the same entry
	plf_ctrl #(
		.BANK_BYTES (BANK_BYTES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.in_item   (in_item),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.info_s1   (info_s1)
	);

	// both banks, bank select is the top address bit
	plf_bank_mem #(
		.BANK_BYTES (BANK_BYTES)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// read stage plus output register
	plf_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.info_s1   (info_s1),
		.mem_rdata (mem_rdata),
		.s1_free   (s1_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

@@ src/plf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plf_checker
// port-level checks on both channels of the frame loader
// ----------------------------------------------------------------------------
module plf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input plf_pkg::plf_in_t   in_item,
	input logic               out_valid,
	input logic               out_ready,
	input plf_pkg::plf_out_t  out_item
);
	import plf_pkg::*;

	// an offered item holds until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_item))
		else $error("input item changed while waiting");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// only defined event codes leave the block
	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.event_res == EV_NONE || out_item.event_res == EV_JUNK ||
			out_item.event_res == EV_DONE || out_item.event_res == EV_REFUSED ||
			out_item.event_res == EV_READ))
		else $error("undefined event code");

	// junk fields are zero unless a junk byte is reported
	a_junk_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.event_res != EV_JUNK |->
			out_item.junk_count == 2'd0 && out_item.junk_byte == 8'd0)
		else $error("junk fields set on a non-junk result");

	// read data is zero unless a read is answered
	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.event_res != EV_READ |-> out_item.read_data == 8'd0)
		else $error("read data set on a non-read result");

endmodule

bind preamble_frame_pingpong_loader_core plf_checker u_plf_checker (.*);
